// ===== design/mandelbrot_escape_time_top_macros.svh =====
// Assertion helpers used by the asserting file of this block.
// Each macro samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_MACROS_SVH

// Same-cycle implication.
`define MBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mandelbrot escape time check failed");

// Next-cycle implication.
`define MBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mandelbrot escape time check failed");

`endif

// ===== design/mbt_pkg.sv =====
package mbt_pkg;

  // Default coordinate format: signed Q4.28.
  localparam int CoordBitsDefault = 32;
  localparam int FracBitsDefault  = 28;

  // Fixed field widths.
  localparam int CountBits = 16;
  localparam int PixelBits = 12;

  // The shared multiplier consumes this many bits of its second operand per cycle.
  localparam int MulDigitBits = 16;

  localparam int CfgIndexBits = 3;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_REAL_ORIGIN     = 3'd0,
    REG_REAL_STEP       = 3'd1,
    REG_IMAG_ORIGIN     = 3'd2,
    REG_IMAG_STEP       = 3'd3,
    REG_ITERATION_LIMIT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PixelBits-1:0] column;
    logic [PixelBits-1:0] row;
  } mbt_in_t;

  typedef struct packed {
    logic [CountBits-1:0] iteration_count;
    logic                 hit_limit;
    logic [PixelBits-1:0] out_column;
    logic [PixelBits-1:0] out_row;
  } mbt_out_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic start;
    logic frac_shift;  // 1: shift the product right by the fraction width
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR_MUL,
    ST_CR_ADD,
    ST_CI_MUL,
    ST_CI_ADD,
    ST_CHECK,
    ST_ZR2,
    ST_ZI2,
    ST_TEST,
    ST_CROSS,
    ST_UPD_RE0,
    ST_UPD_RE1,
    ST_UPD_IM0,
    ST_UPD_IM1,
    ST_DONE
  } seq_state_e;

endpackage

// ===== design/mandelbrot_escape_time_top.sv =====
// Mandelbrot escape-time engine: one pixel in, one result out.
// Input channel (in_valid_i / in_stall_o / in_data_i): a transfer carries a pixel
// column and row. The pixel maps to c = (real_origin + column*real_step,
// imag_origin + row*imag_step) in signed fixed point, and z = z*z + c is iterated
// from zero until |z|^2 reaches 4.0 or the count reaches iteration_limit.
// Output channel (out_valid_o / out_stall_i / out_data_o): a transfer carries the
// count, the limit flag and the echoed pixel. A receiver stall holds the result
// in the output register; the engine may already take and process the next pixel,
// but it waits in its final state until the output register is free again.
// Pixels are handled one at a time. Every multiply goes through a single shared
// digit-serial multiplier that works on its second operand in NumDig digits
// (NumDig = COORD_BITS/16 rounded up, two at the default width). One iteration
// uses three multiplies and six other steps. Mapping the pixel, the final check
// and handing off the result come on top of the iterations; a pixel that escapes
// after k iterations runs the squares and the escape test once more than one
// that stops at the limit after k iterations.
// Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) is always
// ready and must be written only while no pixel is in flight.
// Reset restores origins (-2.0, -1.0), zero steps and a limit of 256.
`include "mandelbrot_escape_time_top_macros.svh"

module mandelbrot_escape_time_top #(
  parameter int COORD_BITS = mbt_pkg::CoordBitsDefault,
  parameter int FRAC_BITS  = mbt_pkg::FracBitsDefault,
  // The data port is wide enough for a coordinate and for the iteration limit.
  localparam int CfgBits = (COORD_BITS > mbt_pkg::CountBits) ? COORD_BITS
                                                             : mbt_pkg::CountBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mbt_pkg::mbt_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mbt_pkg::mbt_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbt_pkg::CfgIndexBits-1:0]  cfg_index_i,
  input  logic [CfgBits-1:0]                cfg_data_i
);

  localparam logic [COORD_BITS-1:0] RealOriginReset =
      COORD_BITS'(0) - (COORD_BITS'(2) << FRAC_BITS);
  localparam logic [COORD_BITS-1:0] ImagOriginReset =
      COORD_BITS'(0) - (COORD_BITS'(1) << FRAC_BITS);

  // Configuration registers.
  logic [COORD_BITS-1:0]         real_origin_q, real_step_q, imag_origin_q, imag_step_q;
  logic [mbt_pkg::CountBits-1:0] limit_q;

  // Sequencer to multiplier.
  mbt_pkg::mul_req_t     mul_req;
  logic [COORD_BITS-1:0] mul_a, mul_b, mul_res;
  logic                  mul_busy, mul_done;

  // Sequencer to output register.
  logic              seq_busy;
  logic              res_valid, res_ready;
  mbt_pkg::mbt_out_t res_data;

  logic              out_valid_q;
  mbt_pkg::mbt_out_t out_data_q;

  logic in_take;

  assign cfg_ready_o = 1'b1;

  // Writes to an unknown index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= RealOriginReset;
      real_step_q   <= '0;
      imag_origin_q <= ImagOriginReset;
      imag_step_q   <= '0;
      limit_q       <= mbt_pkg::CountBits'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mbt_pkg::cfg_reg_e'(cfg_index_i))
        mbt_pkg::REG_REAL_ORIGIN:     real_origin_q <= cfg_data_i[COORD_BITS-1:0];
        mbt_pkg::REG_REAL_STEP:       real_step_q   <= cfg_data_i[COORD_BITS-1:0];
        mbt_pkg::REG_IMAG_ORIGIN:     imag_origin_q <= cfg_data_i[COORD_BITS-1:0];
        mbt_pkg::REG_IMAG_STEP:       imag_step_q   <= cfg_data_i[COORD_BITS-1:0];
        mbt_pkg::REG_ITERATION_LIMIT: limit_q <= cfg_data_i[mbt_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  // A new pixel is taken only when the sequencer is idle.
  assign in_stall_o = seq_busy;
  assign in_take    = in_valid_i & ~in_stall_o;

  mbt_seq #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_take),
    .pixel_i       (in_data_i),
    .real_origin_i (real_origin_q),
    .real_step_i   (real_step_q),
    .imag_origin_i (imag_origin_q),
    .imag_step_i   (imag_step_q),
    .limit_i       (limit_q),
    .mul_req_o     (mul_req),
    .mul_a_o       (mul_a),
    .mul_b_o       (mul_b),
    .mul_done_i    (mul_done),
    .mul_res_i     (mul_res),
    .busy_o        (seq_busy),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_o    (res_data)
  );

  mbt_mul #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  // Output register: loads when empty or when its current result is transferred.
  assign res_ready = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The engine goes busy right after it takes a pixel.
  `MBT_ASSERT_NEXT(a_busy_after_take, in_take, in_stall_o)
  // No multiply is started while the shared multiplier is still working.
  `MBT_ASSERT_IMP(a_mul_no_overlap, mul_busy, !mul_req.start)
  // A reported count never exceeds the limit.
  `MBT_ASSERT_IMP(a_count_in_range, out_valid_o, out_data_o.iteration_count <= limit_q)
  // The limit flag agrees with the count.
  `MBT_ASSERT_IMP(a_limit_flag, out_valid_o,
                  out_data_o.hit_limit == (out_data_o.iteration_count == limit_q))

endmodule

// ===== design/mbt_mul.sv =====
module mbt_mul #(
  parameter int COORD_BITS = mbt_pkg::CoordBitsDefault,
  parameter int FRAC_BITS  = mbt_pkg::FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mbt_pkg::mul_req_t       req_i,
  input  logic [COORD_BITS-1:0]   a_i,
  input  logic [COORD_BITS-1:0]   b_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [COORD_BITS-1:0]   res_o
);

  localparam int DigBits    = mbt_pkg::MulDigitBits;
  localparam int NumDig     = (COORD_BITS + DigBits - 1) / DigBits;
  localparam int YBits      = NumDig * DigBits;
  localparam int ProdBits   = 2 * COORD_BITS;
  localparam int PpBits     = COORD_BITS + DigBits;
  localparam int DigCntBits = $clog2(NumDig + 1);

  localparam logic [COORD_BITS-1:0] MaxV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MinV = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [ProdBits-1:0]   MinMag = ProdBits'(1) << (COORD_BITS - 1);

  logic [COORD_BITS-1:0] x_q, x_d;
  logic [YBits-1:0]      y_q, y_d;
  logic                  neg_q, neg_d;
  logic                  frac_q, frac_d;
  logic [ProdBits-1:0]   acc_q, acc_d;
  logic [DigCntBits-1:0] dig_q, dig_d;
  logic                  run_q, run_d;
  logic                  sat_q, sat_d;
  logic                  done_q, done_d;
  logic [COORD_BITS-1:0] res_q, res_d;

  logic [COORD_BITS-1:0] mag_a, mag_b;
  logic [PpBits-1:0]     pp;
  logic [ProdBits-1:0]   shifted, lim;
  logic [COORD_BITS-1:0] low;

  assign mag_a = a_i[COORD_BITS-1] ? (~a_i + COORD_BITS'(1)) : a_i;
  assign mag_b = b_i[COORD_BITS-1] ? (~b_i + COORD_BITS'(1)) : b_i;

  // One digit of the second operand per cycle, most significant first.
  assign pp = PpBits'(x_q) * PpBits'(y_q[YBits-1 -: DigBits]);

  assign shifted = frac_q ? (acc_q >> FRAC_BITS) : acc_q;
  assign lim     = neg_q ? MinMag : (MinMag - ProdBits'(1));
  assign low     = shifted[COORD_BITS-1:0];

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    neg_d  = neg_q;
    frac_d = frac_q;
    acc_d  = acc_q;
    dig_d  = dig_q;
    run_d  = run_q;
    sat_d  = 1'b0;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      x_d    = mag_a;
      y_d    = YBits'(mag_b);
      neg_d  = a_i[COORD_BITS-1] ^ b_i[COORD_BITS-1];
      frac_d = req_i.frac_shift;
      acc_d  = '0;
      dig_d  = DigCntBits'(NumDig);
      run_d  = 1'b1;
    end else if (run_q) begin
      acc_d = (acc_q << DigBits) + ProdBits'(pp);
      y_d   = y_q << DigBits;
      dig_d = dig_q - DigCntBits'(1);
      if (dig_q == DigCntBits'(1)) begin
        run_d = 1'b0;
        sat_d = 1'b1;
      end
    end else if (sat_q) begin
      // Truncated magnitude, then sign, then clamp to the coordinate range.
      if (shifted > lim) begin
        res_d = neg_q ? MinV : MaxV;
      end else begin
        res_d = neg_q ? (~low + COORD_BITS'(1)) : low;
      end
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      sat_q  <= 1'b0;
      done_q <= 1'b0;
      dig_q  <= '0;
    end else begin
      run_q  <= run_d;
      sat_q  <= sat_d;
      done_q <= done_d;
      dig_q  <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    neg_q  <= neg_d;
    frac_q <= frac_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign busy_o = run_q | sat_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== design/mbt_seq.sv =====
module mbt_seq #(
  parameter int COORD_BITS = mbt_pkg::CoordBitsDefault,
  parameter int FRAC_BITS  = mbt_pkg::FracBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  mbt_pkg::mbt_in_t               pixel_i,
  input  logic [COORD_BITS-1:0]          real_origin_i,
  input  logic [COORD_BITS-1:0]          real_step_i,
  input  logic [COORD_BITS-1:0]          imag_origin_i,
  input  logic [COORD_BITS-1:0]          imag_step_i,
  input  logic [mbt_pkg::CountBits-1:0]  limit_i,
  output mbt_pkg::mul_req_t              mul_req_o,
  output logic [COORD_BITS-1:0]          mul_a_o,
  output logic [COORD_BITS-1:0]          mul_b_o,
  input  logic                           mul_done_i,
  input  logic [COORD_BITS-1:0]          mul_res_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output mbt_pkg::mbt_out_t              res_data_o
);

  localparam int SumBits = ((COORD_BITS + 1) > (FRAC_BITS + 3)) ? (COORD_BITS + 1)
                                                                 : (FRAC_BITS + 3);
  localparam logic [SumBits-1:0]    Four = SumBits'(4) << FRAC_BITS;
  localparam logic [COORD_BITS-1:0] MaxV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MinV = {1'b1, {(COORD_BITS-1){1'b0}}};

  mbt_pkg::seq_state_e state_q, state_d;

  mbt_pkg::mbt_in_t              pixel_q;
  logic [COORD_BITS-1:0]         cr_q, ci_q, zr_q, zi_q, zr2_q, zi2_q, tmp_q;
  logic [mbt_pkg::CountBits-1:0] count_q;
  logic                          pend_q;

  logic                  mul_state;
  logic                  frac_sel;
  logic [COORD_BITS-1:0] add_a, add_b, add_res;
  logic [COORD_BITS:0]   add_full;
  logic [SumBits-1:0]    mag_sum;
  logic                  escape;
  logic                  count_done;

  // Shared saturating adder.
  assign add_full = {add_a[COORD_BITS-1], add_a} + {add_b[COORD_BITS-1], add_b};
  assign add_res  = (add_full[COORD_BITS] != add_full[COORD_BITS-1])
                  ? (add_full[COORD_BITS] ? MinV : MaxV)
                  : add_full[COORD_BITS-1:0];

  // Both squares are non-negative, so the exact sum is unsigned.
  assign mag_sum    = SumBits'(zr2_q) + SumBits'(zi2_q);
  assign escape     = mag_sum >= Four;
  assign count_done = count_q >= limit_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbt_pkg::ST_IDLE:    if (start_i) state_d = mbt_pkg::ST_CR_MUL;
      mbt_pkg::ST_CR_MUL:  if (mul_done_i) state_d = mbt_pkg::ST_CR_ADD;
      mbt_pkg::ST_CR_ADD:  state_d = mbt_pkg::ST_CI_MUL;
      mbt_pkg::ST_CI_MUL:  if (mul_done_i) state_d = mbt_pkg::ST_CI_ADD;
      mbt_pkg::ST_CI_ADD:  state_d = mbt_pkg::ST_CHECK;
      mbt_pkg::ST_CHECK:   state_d = count_done ? mbt_pkg::ST_DONE : mbt_pkg::ST_ZR2;
      mbt_pkg::ST_ZR2:     if (mul_done_i) state_d = mbt_pkg::ST_ZI2;
      mbt_pkg::ST_ZI2:     if (mul_done_i) state_d = mbt_pkg::ST_TEST;
      mbt_pkg::ST_TEST:    state_d = escape ? mbt_pkg::ST_DONE : mbt_pkg::ST_CROSS;
      mbt_pkg::ST_CROSS:   if (mul_done_i) state_d = mbt_pkg::ST_UPD_RE0;
      mbt_pkg::ST_UPD_RE0: state_d = mbt_pkg::ST_UPD_RE1;
      mbt_pkg::ST_UPD_RE1: state_d = mbt_pkg::ST_UPD_IM0;
      mbt_pkg::ST_UPD_IM0: state_d = mbt_pkg::ST_UPD_IM1;
      mbt_pkg::ST_UPD_IM1: state_d = mbt_pkg::ST_CHECK;
      mbt_pkg::ST_DONE:    if (res_ready_i) state_d = mbt_pkg::ST_IDLE;
      default:             state_d = mbt_pkg::ST_IDLE;
    endcase
  end

  // Outputs and operand selection.
  always_comb begin
    mul_state   = 1'b0;
    frac_sel    = 1'b1;
    mul_a_o     = zr_q;
    mul_b_o     = zr_q;
    add_a       = zr2_q;
    add_b       = ~zi2_q + COORD_BITS'(1);
    busy_o      = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      mbt_pkg::ST_IDLE: busy_o = 1'b0;
      mbt_pkg::ST_CR_MUL: begin
        mul_state = 1'b1;
        frac_sel  = 1'b0;
        mul_a_o   = COORD_BITS'(pixel_q.column);
        mul_b_o   = real_step_i;
      end
      mbt_pkg::ST_CR_ADD: begin
        add_a = real_origin_i;
        add_b = mul_res_i;
      end
      mbt_pkg::ST_CI_MUL: begin
        mul_state = 1'b1;
        frac_sel  = 1'b0;
        mul_a_o   = COORD_BITS'(pixel_q.row);
        mul_b_o   = imag_step_i;
      end
      mbt_pkg::ST_CI_ADD: begin
        add_a = imag_origin_i;
        add_b = mul_res_i;
      end
      mbt_pkg::ST_ZR2: mul_state = 1'b1;
      mbt_pkg::ST_ZI2: begin
        mul_state = 1'b1;
        mul_a_o   = zi_q;
        mul_b_o   = zi_q;
      end
      mbt_pkg::ST_CROSS: begin
        mul_state = 1'b1;
        mul_b_o   = zi_q;
      end
      mbt_pkg::ST_UPD_RE1: begin
        add_a = tmp_q;
        add_b = cr_q;
      end
      mbt_pkg::ST_UPD_IM0: begin
        // The multiplier still holds zr*zi.
        add_a = mul_res_i;
        add_b = mul_res_i;
      end
      mbt_pkg::ST_UPD_IM1: begin
        add_a = tmp_q;
        add_b = ci_q;
      end
      mbt_pkg::ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
    mul_req_o.start      = mul_state & ~pend_q;
    mul_req_o.frac_shift = frac_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbt_pkg::ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_req_o.start) begin
        pend_q <= 1'b1;
      end else if (mul_done_i) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mbt_pkg::ST_IDLE:    if (start_i) pixel_q <= pixel_i;
      mbt_pkg::ST_CR_ADD:  cr_q <= add_res;
      mbt_pkg::ST_CI_ADD: begin
        ci_q    <= add_res;
        zr_q    <= '0;
        zi_q    <= '0;
        count_q <= '0;
      end
      mbt_pkg::ST_ZR2:     if (mul_done_i) zr2_q <= mul_res_i;
      mbt_pkg::ST_ZI2:     if (mul_done_i) zi2_q <= mul_res_i;
      mbt_pkg::ST_UPD_RE0: tmp_q <= add_res;
      mbt_pkg::ST_UPD_RE1: zr_q <= add_res;
      mbt_pkg::ST_UPD_IM0: tmp_q <= add_res;
      mbt_pkg::ST_UPD_IM1: begin
        zi_q    <= add_res;
        count_q <= count_q + mbt_pkg::CountBits'(1);
      end
      default: ;
    endcase
  end

  assign res_data_o.iteration_count = count_q;
  assign res_data_o.hit_limit       = (count_q == limit_i);
  assign res_data_o.out_column      = pixel_q.column;
  assign res_data_o.out_row         = pixel_q.row;

endmodule
